/* src/kce_pkg.sv */
// ----------------------------------------------------------------------------
// kce_pkg
// Types, constants and the scan decoder shared by the keypad entry block.
// ----------------------------------------------------------------------------
package kce_pkg;

    typedef struct packed {
        logic        kind;
        logic [15:0] scan_word;
    } t_in_word;

    typedef struct packed {
        logic [3:0] entry_status;
        logic [9:0] entered_number;
        logic [3:0] first_digit;
        logic [3:0] second_digit;
        logic [3:0] third_digit;
        logic [1:0] beep_command;
        logic [3:0] display_command;
        logic       display_refresh;
    } t_out_word;

    localparam int unsigned NUM_KEYS = 12;
    localparam int unsigned PADDR_W  = 5;

    localparam logic [PADDR_W-1:0] ADDR_INTERDIGIT = 5'd0;
    localparam logic [PADDR_W-1:0] ADDR_SAMPLE     = 5'd4;
    localparam logic [PADDR_W-1:0] ADDR_STAR       = 5'd8;
    localparam logic [PADDR_W-1:0] ADDR_ZERO       = 5'd12;
    localparam logic [PADDR_W-1:0] ADDR_POUND      = 5'd16;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    localparam logic [1:0] BEEP_NONE  = 2'd0;
    localparam logic [1:0] BEEP_ONE   = 2'd1;
    localparam logic [1:0] BEEP_TWO   = 2'd2;
    localparam logic [1:0] BEEP_HALF  = 2'd3;

    localparam logic [3:0] DISP_BLANK = 4'd10;
    localparam logic [3:0] DISP_KEEP  = 4'd11;

    localparam logic [3:0] KEY_NONE   = 4'd0;
    localparam logic [3:0] KEY_NINE   = 4'd9;

    localparam logic [15:0] INTERDIGIT_RESET = 16'd3000;
    localparam logic [7:0]  SAMPLE_RESET     = 8'd50;
    localparam logic [3:0]  STAR_RESET       = 4'd10;
    localparam logic [3:0]  ZERO_RESET       = 4'd11;
    localparam logic [3:0]  POUND_RESET      = 4'd12;

    localparam logic [15:0] SCAN_TABLE [NUM_KEYS] = '{
        16'hBFBE, 16'hBFBD, 16'hBFBB, 16'hBFB7, 16'hBFAF, 16'hBF9F,
        16'hBEBF, 16'hBDBF, 16'hBBBF, 16'hB7BF, 16'hAFBF, 16'h9FBF
    };

    function automatic logic [3:0] decode_scan(input logic [15:0] word);
        logic [3:0] key;
        key = KEY_NONE;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (SCAN_TABLE[i] == word) begin
                key = 4'(i + 1);
            end
        end
        return key;
    endfunction

endpackage

/* src/keypad_code_entry_fsm.sv */
// ----------------------------------------------------------------------------
// keypad_code_entry_fsm
// Keypad controller that collects a one to three digit code from scan words.
// ----------------------------------------------------------------------------
// Each word is either a timer tick, which counts down the sample-hold and
// inter-digit timers and yields nothing, or a poll, which samples the keypad
// scan word when the hold timer has run out, steps the entry state machine
// once and yields one result word with status, code, digit slots and beep
// and display commands. A word passes an input register and one stage of
// state update logic into the result register, so a new word is taken every
// cycle unless the input register stalls. A result that waits on a stall
// holds the next poll, and every word behind it, in the input register.
// Timer reloads and key codes are set through the APB registers; the user
// must write them only while idle, which the block itself does not enforce.
module keypad_code_entry_fsm (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  kce_pkg::t_in_word        i_in_word,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output kce_pkg::t_out_word       o_out_word,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [kce_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import kce_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_A          = 4'd1,
        ST_B          = 4'd2,
        ST_C          = 4'd3,
        ST_D          = 4'd4,
        ST_E          = 4'd5,
        ST_F          = 4'd6,
        ST_CANCELLING = 4'd7,
        ST_FINISH     = 4'd8,
        ST_CANCEL     = 4'd9,
        ST_TIMEOUT    = 4'd10
    } t_state;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_DIGIT,
        CLS_STAR,
        CLS_POUND,
        CLS_OTHER
    } t_class;

    logic [15:0] r_interdigit_ticks;
    logic [7:0]  r_sample_ticks;
    logic [3:0]  r_star_code;
    logic [3:0]  r_zero_code;
    logic [3:0]  r_pound_code;

    logic        r_in_vld;
    t_in_word    r_in;
    logic        r_out_vld;
    t_out_word   r_out;

    t_state      r_state, n_state;
    logic [3:0]  r_held_key, n_held_key;
    logic [7:0]  r_sample_cnt, n_sample_cnt;
    logic [15:0] r_inter_cnt, n_inter_cnt;
    logic [3:0]  r_slot0, n_slot0;
    logic [3:0]  r_slot1, n_slot1;
    logic [3:0]  r_slot2, n_slot2;
    logic [9:0]  r_number, n_number;
    t_out_word   n_out;

    logic        fire;
    logic        fire_poll;
    logic        in_accept;
    logic        cfg_write;
    t_class      cls;
    logic [3:0]  digit;
    logic        check_timeout;
    logic [1:0]  beep;
    logic [3:0]  disp;
    logic        refresh;

    assign fire      = r_in_vld && ((r_in.kind == KIND_TICK) || !r_out_vld || !i_out_stall);
    assign fire_poll = fire && (r_in.kind == KIND_POLL);
    assign o_in_stall = r_in_vld && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_write  = psel && penable && pwrite;
    assign pready     = 1'b1;

    always_comb begin
        case (paddr)
            ADDR_INTERDIGIT: prdata = {16'd0, r_interdigit_ticks};
            ADDR_SAMPLE:     prdata = {24'd0, r_sample_ticks};
            ADDR_STAR:       prdata = {28'd0, r_star_code};
            ADDR_ZERO:       prdata = {28'd0, r_zero_code};
            ADDR_POUND:      prdata = {28'd0, r_pound_code};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_held_key   = r_held_key;
        n_sample_cnt = r_sample_cnt;
        n_inter_cnt  = r_inter_cnt;
        n_slot0      = r_slot0;
        n_slot1      = r_slot1;
        n_slot2      = r_slot2;
        n_number     = r_number;
        beep         = BEEP_NONE;
        disp         = DISP_KEEP;
        refresh      = 1'b0;
        check_timeout = 1'b0;
        cls          = CLS_NONE;
        digit        = 4'd0;

        if (r_in.kind == KIND_TICK) begin
            if (r_sample_cnt != 8'd0) begin
                n_sample_cnt = r_sample_cnt - 8'd1;
            end
            if (r_inter_cnt != 16'd0) begin
                n_inter_cnt = r_inter_cnt - 16'd1;
            end
        end else begin
            if (r_sample_cnt == 8'd0) begin
                n_held_key   = decode_scan(r_in.scan_word);
                refresh      = 1'b1;
                n_sample_cnt = r_sample_ticks;
            end

            if (n_held_key == KEY_NONE) begin
                cls = CLS_NONE;
            end else if (n_held_key == r_star_code) begin
                cls = CLS_STAR;
            end else if (n_held_key == r_pound_code) begin
                cls = CLS_POUND;
            end else if (n_held_key == r_zero_code) begin
                cls = CLS_DIGIT;
            end else if (n_held_key <= KEY_NINE) begin
                cls   = CLS_DIGIT;
                digit = n_held_key;
            end else begin
                cls = CLS_OTHER;
            end

            case (r_state)
                ST_IDLE: begin
                    if (cls == CLS_DIGIT) begin
                        n_slot0     = digit;
                        n_slot1     = 4'd0;
                        n_slot2     = 4'd0;
                        disp        = digit;
                        beep        = BEEP_ONE;
                        n_inter_cnt = r_interdigit_ticks;
                        n_state     = ST_A;
                    end else if (cls == CLS_STAR) begin
                        n_state = ST_CANCELLING;
                    end
                end
                ST_A, ST_C, ST_E: begin
                    if (cls == CLS_NONE) begin
                        disp        = DISP_BLANK;
                        n_state     = t_state'(r_state + 4'd1);
                        n_inter_cnt = r_interdigit_ticks;
                    end
                    check_timeout = 1'b1;
                end
                ST_B, ST_D: begin
                    if (cls == CLS_STAR) begin
                        n_state = ST_CANCELLING;
                    end else if (cls == CLS_DIGIT) begin
                        if (r_state == ST_B) begin
                            n_slot1 = digit;
                        end else begin
                            n_slot2 = digit;
                        end
                        disp        = digit;
                        beep        = BEEP_ONE;
                        n_state     = t_state'(r_state + 4'd1);
                        n_inter_cnt = r_interdigit_ticks;
                    end else if (cls == CLS_POUND) begin
                        beep    = BEEP_TWO;
                        n_slot2 = r_slot0;
                        if (r_state == ST_B) begin
                            n_slot0  = 4'd0;
                            n_number = {6'd0, r_slot0};
                        end else begin
                            n_number = 10'({6'd0, r_slot0} * 10'd10 + {6'd0, r_slot1});
                        end
                        n_state = ST_FINISH;
                    end
                    check_timeout = 1'b1;
                end
                ST_F: begin
                    if (cls == CLS_STAR) begin
                        n_state = ST_CANCELLING;
                    end else if (cls == CLS_POUND) begin
                        beep     = BEEP_TWO;
                        n_number = 10'({6'd0, r_slot0} * 10'd100 +
                                       {6'd0, r_slot1} * 10'd10 + {6'd0, r_slot2});
                        n_state  = ST_FINISH;
                    end
                    check_timeout = 1'b1;
                end
                ST_CANCELLING: begin
                    disp    = DISP_BLANK;
                    beep    = BEEP_HALF;
                    n_state = ST_CANCEL;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase

            if (check_timeout && (n_inter_cnt == 16'd0)) begin
                n_state = ST_TIMEOUT;
            end
        end

        n_out.entry_status    = n_state;
        n_out.entered_number  = n_number;
        n_out.first_digit     = n_slot0;
        n_out.second_digit    = n_slot1;
        n_out.third_digit     = n_slot2;
        n_out.beep_command    = beep;
        n_out.display_command = disp;
        n_out.display_refresh = refresh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interdigit_ticks <= INTERDIGIT_RESET;
            r_sample_ticks     <= SAMPLE_RESET;
            r_star_code        <= STAR_RESET;
            r_zero_code        <= ZERO_RESET;
            r_pound_code       <= POUND_RESET;
            r_in_vld           <= 1'b0;
            r_out_vld          <= 1'b0;
            r_state            <= ST_IDLE;
            r_held_key         <= KEY_NONE;
            r_sample_cnt       <= 8'd0;
            r_inter_cnt        <= 16'd0;
            r_slot0            <= 4'd0;
            r_slot1            <= 4'd0;
            r_slot2            <= 4'd0;
            r_number           <= 10'd0;
        end else begin
            if (cfg_write) begin
                case (paddr)
                    ADDR_INTERDIGIT: r_interdigit_ticks <= pwdata[15:0];
                    ADDR_SAMPLE:     r_sample_ticks     <= pwdata[7:0];
                    ADDR_STAR:       r_star_code        <= pwdata[3:0];
                    ADDR_ZERO:       r_zero_code        <= pwdata[3:0];
                    ADDR_POUND:      r_pound_code       <= pwdata[3:0];
                    default: begin
                    end
                endcase
            end

            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end

            if (fire_poll) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            if (fire) begin
                r_state      <= n_state;
                r_held_key   <= n_held_key;
                r_sample_cnt <= n_sample_cnt;
                r_inter_cnt  <= n_inter_cnt;
                r_slot0      <= n_slot0;
                r_slot1      <= n_slot1;
                r_slot2      <= n_slot2;
                r_number     <= n_number;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (fire_poll) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule
